### sv/gjmi_pkg.sv
package gjmi_pkg;

    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 4;
    localparam int FRAC_W   = 16;
    localparam int DIV_BITS = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SWP_RD,
        ST_SWP_WA,
        ST_SWP_WB,
        ST_ELIM_RD,
        ST_ELIM_DIV,
        ST_ELIM_WAIT,
        ST_ROW_RD,
        ST_MULW,
        ST_SUBW,
        ST_MULI,
        ST_SUBI,
        ST_SING,
        ST_NORM_RD,
        ST_NORM_PIV,
        ST_OUT_RD,
        ST_OUT_DIV,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        return {row, col};
    endfunction

endpackage

### sv/gauss_jordan_matrix_inverse.sv
// Elements load row by row, none alongside a size write; the last element starts the inversion.
// Each elimination step forms the factor in the shared divider and then updates the target
// row of both matrices; a row swap searches the lower rows, then swaps two rows of both matrices.
// For a nonsingular matrix each of the n*n results is scaled in the divider and held until taken.
// Reset clears the sequencer and output valid and sets the size to 8; memories are not cleared.
module gauss_jordan_matrix_inverse
    import gjmi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,    // [31:0] element_value
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,    // [31:0] inverse_value
    output logic              m_tuser,    // [0] singular
    output logic              m_tlast,    // last_result
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata   // matrix_size
);

    // Sequencer state. The counters i and k serve as row and column while
    // loading, and i, j and k as pivot row, target row and column while solving.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               bwd_reg, bwd_next;
    logic [DATA_W-1:0]  piv_reg, piv_next;
    logic [DATA_W-1:0]  f_reg, f_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic signed [2*DATA_W-1:0] mul_reg, mul_next;

    logic               m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;
    logic               m_last_reg, m_last_next;

    // Effective dimension: zero acts as one, anything above the maximum as the maximum.
    logic [SIZE_W-1:0]  n_eff;
    logic [SIZE_W-1:0]  n_less;
    logic [IDX_W-1:0]   nm1;

    always_comb begin
        if (size_reg == '0) begin
            n_eff = SIZE_W'(1);
        end else if (size_reg > SIZE_W'(MAX_DIM)) begin
            n_eff = SIZE_W'(MAX_DIM);
        end else begin
            n_eff = size_reg;
        end
        n_less = n_eff - 1'b1;
        nm1    = n_less[IDX_W-1:0];
    end

    // Work and inverse matrices: two read ports and one write port each.
    logic [DATA_W-1:0] work_mem [DEPTH];
    logic [DATA_W-1:0] inv_mem  [DEPTH];

    logic [ADDR_W-1:0] w_ra, w_rb, w_wa;
    logic [ADDR_W-1:0] i_ra, i_rb, i_wa;
    logic              w_we, i_we;
    logic [DATA_W-1:0] w_wd, i_wd;
    logic [DATA_W-1:0] w_rda, w_rdb, i_rda, i_rdb;

    always_ff @(posedge aclk) begin
        if (w_we) begin
            work_mem[w_wa] <= w_wd;
        end
        w_rda <= work_mem[w_ra];
        w_rdb <= work_mem[w_rb];
    end

    always_ff @(posedge aclk) begin
        if (i_we) begin
            inv_mem[i_wa] <= i_wd;
        end
        i_rda <= inv_mem[i_ra];
        i_rdb <= inv_mem[i_rb];
    end

    // Shared divider, used for elimination factors and for the final scaling.
    logic              div_start;
    logic [DATA_W-1:0] div_a;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    gjmi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (piv_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Row update: the registered product is rounded half up to Q16.16, saturated,
    // and subtracted from the target entry with saturation.
    logic signed [2*DATA_W-1:0] prod_rnd;
    logic [2*DATA_W-FRAC_W-1:0] prod_sh;
    logic [DATA_W-1:0]          prod_q;
    logic [DATA_W-1:0]          sub_src;
    logic [DATA_W:0]            diff;
    logic [DATA_W-1:0]          sub_res;
    logic [DATA_W-1:0]          mul_src;

    always_comb begin
        prod_rnd = mul_reg + 64'sd32768;
        prod_sh  = prod_rnd[2*DATA_W-1:FRAC_W];
        if (prod_sh[2*DATA_W-FRAC_W-1:DATA_W-1] == '0 ||
            prod_sh[2*DATA_W-FRAC_W-1:DATA_W-1] == '1) begin
            prod_q = prod_sh[DATA_W-1:0];
        end else begin
            prod_q = prod_sh[2*DATA_W-FRAC_W-1] ? Q_MIN : Q_MAX;
        end
        sub_src = (state_reg == ST_SUBI) ? i_rdb : w_rdb;
        diff    = {sub_src[DATA_W-1], sub_src} - {prod_q[DATA_W-1], prod_q};
        if (diff[DATA_W] != diff[DATA_W-1]) begin
            sub_res = diff[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
            sub_res = diff[DATA_W-1:0];
        end
        mul_src = (state_reg == ST_MULI) ? i_rda : w_rda;
    end

    // Next state and sequencer registers.
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        bwd_next     = bwd_reg;
        piv_next     = piv_reg;
        f_next       = f_reg;
        size_next    = size_reg;
        mul_next     = mul_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        if (cfg_we) begin
            size_next = cfg_wdata;
        end

        case (state_reg)
            ST_LOAD: begin
                if (cfg_we) begin
                    // A size write restarts loading.
                    i_next = '0;
                    k_next = '0;
                end else if (s_tvalid) begin
                    if (k_reg == nm1) begin
                        k_next = '0;
                        if (i_reg == nm1) begin
                            i_next     = '0;
                            state_next = ST_INIT;
                        end else begin
                            i_next = i_reg + 1'b1;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_INIT: begin
                if (k_reg == nm1) begin
                    k_next = '0;
                    if (i_reg == nm1) begin
                        i_next     = '0;
                        bwd_next   = 1'b0;
                        state_next = ST_PIV_RD;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_PIV_RD: begin
                state_next = ST_PIV_CHK;
            end
            ST_PIV_CHK: begin
                if (bwd_reg) begin
                    piv_next   = w_rda;
                    j_next     = i_reg - 1'b1;
                    state_next = ST_ELIM_RD;
                end else if (w_rda != '0) begin
                    piv_next = w_rda;
                    if (i_reg == nm1) begin
                        if (nm1 == '0) begin
                            i_next     = '0;
                            k_next     = '0;
                            state_next = ST_NORM_RD;
                        end else begin
                            bwd_next   = 1'b1;
                            state_next = ST_PIV_RD;
                        end
                    end else begin
                        j_next     = i_reg + 1'b1;
                        state_next = ST_ELIM_RD;
                    end
                end else if (i_reg == nm1) begin
                    state_next = ST_SING;
                end else begin
                    j_next     = i_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
                if (w_rda != '0) begin
                    k_next     = '0;
                    state_next = ST_SWP_RD;
                end else if (j_reg == nm1) begin
                    state_next = ST_SING;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SWP_RD: begin
                state_next = ST_SWP_WA;
            end
            ST_SWP_WA: begin
                state_next = ST_SWP_WB;
            end
            ST_SWP_WB: begin
                if (k_reg == nm1) begin
                    k_next     = '0;
                    state_next = ST_PIV_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SWP_RD;
                end
            end
            ST_ELIM_RD: begin
                state_next = ST_ELIM_DIV;
            end
            ST_ELIM_DIV: begin
                state_next = ST_ELIM_WAIT;
            end
            ST_ELIM_WAIT: begin
                if (div_done) begin
                    f_next     = div_q;
                    k_next     = '0;
                    state_next = ST_ROW_RD;
                end
            end
            ST_ROW_RD: begin
                state_next = ST_MULW;
            end
            ST_MULW: begin
                mul_next   = $signed(mul_src) * $signed(f_reg);
                state_next = ST_SUBW;
            end
            ST_SUBW: begin
                state_next = ST_MULI;
            end
            ST_MULI: begin
                mul_next   = $signed(mul_src) * $signed(f_reg);
                state_next = ST_SUBI;
            end
            ST_SUBI: begin
                if (k_reg != nm1) begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ROW_RD;
                end else begin
                    k_next = '0;
                    if (!bwd_reg) begin
                        if (j_reg == nm1) begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_PIV_RD;
                        end else begin
                            j_next     = j_reg + 1'b1;
                            state_next = ST_ELIM_RD;
                        end
                    end else if (j_reg == '0) begin
                        if (i_reg == IDX_W'(1)) begin
                            i_next     = '0;
                            state_next = ST_NORM_RD;
                        end else begin
                            i_next     = i_reg - 1'b1;
                            state_next = ST_PIV_RD;
                        end
                    end else begin
                        j_next     = j_reg - 1'b1;
                        state_next = ST_ELIM_RD;
                    end
                end
            end
            ST_SING: begin
                m_valid_next = 1'b1;
                m_data_next  = '0;
                m_user_next  = 1'b1;
                m_last_next  = 1'b1;
                state_next   = ST_OUT_HOLD;
            end
            ST_NORM_RD: begin
                state_next = ST_NORM_PIV;
            end
            ST_NORM_PIV: begin
                piv_next   = w_rda;
                state_next = ST_OUT_RD;
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_DIV;
            end
            ST_OUT_DIV: begin
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (div_done) begin
                    m_valid_next = 1'b1;
                    m_data_next  = div_q;
                    m_user_next  = 1'b0;
                    m_last_next  = (i_reg == nm1) && (k_reg == nm1);
                    state_next   = ST_OUT_HOLD;
                end
            end
            ST_OUT_HOLD: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        i_next     = '0;
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end else if (k_reg == nm1) begin
                        k_next     = '0;
                        i_next     = i_reg + 1'b1;
                        state_next = ST_NORM_RD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Memory strobes, addresses and divider start.
    always_comb begin
        w_we      = 1'b0;
        i_we      = 1'b0;
        w_wa      = cell_addr(i_reg, k_reg);
        i_wa      = cell_addr(i_reg, k_reg);
        w_wd      = s_tdata;
        i_wd      = '0;
        w_rb      = cell_addr(j_reg, k_reg);
        i_ra      = cell_addr(i_reg, k_reg);
        i_rb      = cell_addr(j_reg, k_reg);
        div_start = 1'b0;
        div_a     = w_rda;

        case (state_reg)
            ST_PIV_RD, ST_NORM_RD:  w_ra = cell_addr(i_reg, i_reg);
            ST_SRCH_RD, ST_ELIM_RD: w_ra = cell_addr(j_reg, i_reg);
            default:                w_ra = cell_addr(i_reg, k_reg);
        endcase

        case (state_reg)
            ST_LOAD: begin
                w_we = s_tvalid && !cfg_we;
            end
            ST_INIT: begin
                i_we = 1'b1;
                i_wd = (i_reg == k_reg) ? Q_ONE : '0;
            end
            ST_SWP_WA: begin
                w_we = 1'b1;
                w_wd = w_rdb;
                i_we = 1'b1;
                i_wd = i_rdb;
            end
            ST_SWP_WB: begin
                w_we = 1'b1;
                w_wa = cell_addr(j_reg, k_reg);
                w_wd = w_rda;
                i_we = 1'b1;
                i_wa = cell_addr(j_reg, k_reg);
                i_wd = i_rda;
            end
            ST_ELIM_DIV: begin
                div_start = 1'b1;
                div_a     = w_rda;
            end
            ST_SUBW: begin
                // The pivot column of the target row is cleared exactly.
                w_we = 1'b1;
                w_wa = cell_addr(j_reg, k_reg);
                w_wd = (k_reg == i_reg) ? '0 : sub_res;
            end
            ST_SUBI: begin
                i_we = 1'b1;
                i_wa = cell_addr(j_reg, k_reg);
                i_wd = sub_res;
            end
            ST_OUT_DIV: begin
                div_start = 1'b1;
                div_a     = i_rda;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            bwd_reg     <= 1'b0;
            size_reg    <= SIZE_W'(MAX_DIM);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            bwd_reg     <= bwd_next;
            size_reg    <= size_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        piv_reg    <= piv_next;
        f_reg      <= f_next;
        mul_reg    <= mul_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    // A size write takes the cycle, so no item is accepted alongside it.
    assign s_tready = (state_reg == ST_LOAD) && !cfg_we;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // A result is only offered while the sequencer waits for it to be taken.
    a_valid_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == ST_OUT_HOLD)
        else $error("result offered outside the hold state");

    // The divider only finishes while the sequencer is waiting on it.
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_ELIM_WAIT || state_reg == ST_OUT_WAIT))
        else $error("divider finished while not awaited");

    // A singular flag comes as the only, final item with a zero value.
    a_singular_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("malformed singular result");

    // Taking the final item returns the block to loading.
    a_last_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == ST_LOAD))
        else $error("block did not return to loading after the final item");

endmodule

### sv/gjmi_div.sv
module gjmi_div
    import gjmi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    // Restoring division of (dividend * 2^16) by divisor, one quotient bit per cycle.
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W:0]      rem_reg;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [DATA_W-1:0]    dvs_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    logic                 apos_reg;
    logic [DATA_W-1:0]    q_reg;

    logic [DATA_W-1:0]    a_mag;
    logic [DATA_W-1:0]    b_mag;
    logic [DATA_W:0]      rem_sh;
    logic                 ge;
    logic [DIV_BITS-1:0]  quo_new;
    logic [DATA_W-1:0]    q_final;

    always_comb begin
        a_mag   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
        b_mag   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
        rem_sh  = {rem_reg[DATA_W-1:0], quo_reg[DIV_BITS-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        quo_new = {quo_reg[DIV_BITS-2:0], ge};
        if (zero_reg) begin
            q_final = apos_reg ? Q_MAX : Q_MIN;
        end else if (neg_reg) begin
            if (quo_new > DIV_BITS'({1'b0, Q_MIN})) begin
                q_final = Q_MIN;
            end else begin
                q_final = ~quo_new[DATA_W-1:0] + 1'b1;
            end
        end else begin
            if (quo_new > DIV_BITS'({1'b0, Q_MAX})) begin
                q_final = Q_MAX;
            end else begin
                q_final = quo_new[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= {a_mag, {FRAC_W{1'b0}}};
            rem_reg  <= '0;
            dvs_reg  <= b_mag;
            neg_reg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            zero_reg <= (divisor == '0);
            apos_reg <= ~dividend[DATA_W-1];
        end else if (busy_reg) begin
            quo_reg <= quo_new;
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1)) begin
                q_reg <= q_final;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the fixed-point Gauss-Jordan inverter.
module testbench;
    import gjmi_pkg::*;

    localparam int IDLE_LIMIT = 60000;   // cycles with no handshake at all
    localparam int MIN_ITEMS  = 130;

    typedef struct {
        int value;
        bit singular;
        bit last;
    } inv_result_t;

    // Scoreboard: keeps its own copy of the loaded matrix and size, runs the
    // inversion when the final element of a matrix arrives, and queues the
    // inverse elements (or a single singular flag) that the block must emit.
    class inverse_scoreboard;
        int work[MAX_DIM][MAX_DIM];
        int inv[MAX_DIM][MAX_DIM];
        int loaded;
        int size_reg;
        int errors;
        inv_result_t expected_q[$];

        function new();
            loaded = 0;
            size_reg = MAX_DIM;
            errors = 0;
        endfunction

        function int dim();
            if (size_reg < 1) return 1;
            if (size_reg > MAX_DIM) return MAX_DIM;
            return size_reg;
        endfunction

        function int sat(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return int'(v);
        endfunction

        // Product with round half up; the arithmetic shift floors.
        function int qmul(int a, int b);
            longint p;
            p = longint'(a) * longint'(b) + 64'sd32768;
            return sat(p >>> 16);
        endfunction

        // Quotient truncated toward zero.
        function int qdiv(int a, int b);
            if (b == 0) return (a >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            return sat((longint'(a) * 64'sd65536) / longint'(b));
        endfunction

        function void row_update(int n, int src, int dst, int f);
            for (int k = 0; k < n; k++) begin
                work[dst][k] = sat(longint'(work[dst][k]) - longint'(qmul(work[src][k], f)));
                inv[dst][k] = sat(longint'(inv[dst][k]) - longint'(qmul(inv[src][k], f)));
            end
        endfunction

        function bit invert(int n);
            int k, f, d, tmp;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    inv[i][j] = (i == j) ? 32'h0001_0000 : 0;
            for (int i = 0; i < n; i++) begin
                if (work[i][i] == 0) begin
                    // Zero pivot: swap in the first lower row that has a nonzero entry.
                    k = i + 1;
                    while (k < n && work[k][i] == 0) k++;
                    if (k >= n) return 0;
                    for (int c = 0; c < MAX_DIM; c++) begin
                        tmp = work[i][c]; work[i][c] = work[k][c]; work[k][c] = tmp;
                        tmp = inv[i][c]; inv[i][c] = inv[k][c]; inv[k][c] = tmp;
                    end
                end
                for (int j = i + 1; j < n; j++) begin
                    f = qdiv(work[j][i], work[i][i]);
                    row_update(n, i, j, f);
                    work[j][i] = 0;
                end
            end
            for (int i = n - 1; i >= 1; i--)
                for (int j = i - 1; j >= 0; j--) begin
                    f = qdiv(work[j][i], work[i][i]);
                    row_update(n, i, j, f);
                    work[j][i] = 0;
                end
            for (int i = 0; i < n; i++) begin
                d = work[i][i];
                for (int c = 0; c < n; c++) begin
                    work[i][c] = qdiv(work[i][c], d);
                    inv[i][c] = qdiv(inv[i][c], d);
                end
            end
            return 1;
        endfunction

        function void write_size(int v);
            size_reg = v & 15;
            loaded = 0;
        endfunction

        function void note_element(int v);
            int n;
            inv_result_t r;
            n = dim();
            if (loaded >= n * n) loaded = 0;
            work[loaded / n][loaded % n] = v;
            loaded++;
            if (loaded < n * n) return;
            loaded = 0;
            if (!invert(n)) begin
                r.value = 0; r.singular = 1; r.last = 1;
                expected_q.push_back(r);
                return;
            end
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    r.value = inv[i][j];
                    r.singular = 0;
                    r.last = (i == n - 1 && j == n - 1);
                    expected_q.push_back(r);
                end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(int value, bit singular, bit last);
            inv_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result data=%h user=%b last=%b",
                                 value, singular, last));
                return;
            end
            e = expected_q.pop_front();
            if (value != e.value)
                report($sformatf("inverse_value %h, expected %h", value, e.value));
            if (singular != e.singular)
                report($sformatf("singular %b, expected %b", singular, e.singular));
            if (last != e.last)
                report($sformatf("last_result %b, expected %b", last, e.last));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    inverse_scoreboard sb;
    int  items_sent;
    int  hold_request;   // receiver holds ready low this many cycles when set
    int  quiet_cycles;
    int  big_done;

    gauss_jordan_matrix_inverse dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Watchdog: the run ends when no item, result or register write has moved
    // for far longer than the slowest 8x8 inversion plus the longest stall.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Often no gap at all, otherwise mostly a short one and now and then a long one.
    function int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // Receiver: alternates between stretches of steady ready and stretches
    // with random stalls; a hold request forces a long stretch of not ready.
    initial begin
        int stretch;
        bit steady;
        stretch = 0;
        steady = 1;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                m_tready = 1'b0;
                hold_request--;
            end else begin
                if (stretch == 0) begin
                    steady = $urandom_range(1);
                    stretch = $urandom_range(80, 10);
                end
                stretch--;
                if (steady) begin
                    m_tready = 1'b1;
                end else if (m_tready && gap_length() > 0) begin
                    m_tready = 1'b0;
                end else begin
                    m_tready = ($urandom_range(3) != 0);
                end
            end
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    task send_element(int v);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = v;
        do @(posedge aclk); while (!s_tready);
        sb.note_element(v);
        items_sent++;
        @(negedge aclk);
    endtask

    // Leaves the input idle until every expected result has been collected,
    // then lets the block finish its output handshake before anything else.
    task drain();
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task write_size(int v);
        drain();
        cfg_wdata = SIZE_W'(v);
        cfg_we = 1'b1;
        @(posedge aclk);
        sb.write_size(v);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Fills one matrix of the current size. Kinds: 0 well conditioned with a
    // dominant diagonal, 1 zeros on the diagonal but for its last entry, which
    // forces row swaps, 2 a zero column (singular), 3 raw 32-bit values anywhere in the range.
    task send_matrix(int kind);
        int n, v, zc;
        n = sb.dim();
        zc = $urandom_range(n - 1);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                v = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
                if (r == c)
                    v = (v < 0) ? v - n * 32'sh0003_0000 : v + n * 32'sh0003_0000;
                case (kind)
                    1: if (r == c && r + 1 < n) v = 0;
                    2: if (c == zc) v = 0;
                    3: v = $urandom();
                    default: ;
                endcase
                send_element(v);
            end
    endtask

    initial begin
        int kind, roll;
        sb = new();
        items_sent = 0;
        hold_request = 0;
        quiet_cycles = 0;
        big_done = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part. A 1x1 zero matrix is singular; the extremes of the
        // element range invert with saturation.
        write_size(1);
        send_element(0);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h0000_0001);
        // Size zero behaves as a 1x1 matrix.
        write_size(0);
        send_element(32'hFFFF_0000);
        // A permutation matrix needs a row swap at the first pivot.
        write_size(2);
        send_element(0); send_element(32'h0001_0000);
        send_element(32'h0001_0000); send_element(0);
        // Swap succeeds, then the second pivot has no nonzero candidate.
        send_element(0); send_element(0);
        send_element(32'h0001_0000); send_element(32'h0001_0000);
        // A size write in the middle of a load restarts loading.
        write_size(3);
        send_element(32'h0002_0000); send_element(32'h0001_0000);
        send_element(32'h0003_0000); send_element(32'h0000_8000);
        write_size(2);
        send_element(32'h0002_0000); send_element(32'h0001_0000);
        send_element(32'h0001_0000); send_element(32'h0003_0000);

        // Random part. The receiver blocks for a long time right after the
        // first matrix completes while the sender keeps offering the next one,
        // so the block fills up and stalls its input.
        write_size(3);
        send_matrix(0);
        hold_request = 3000;
        send_matrix(1);
        while (items_sent < MIN_ITEMS || !big_done) begin
            roll = $urandom_range(99);
            if (!big_done && items_sent > 60) begin
                // Out-of-range size acts as the largest one; done once only.
                write_size(15);
                big_done = 1;
            end else if (roll < 35 || sb.dim() == MAX_DIM) begin
                write_size($urandom_range(3, 1));
            end else if (roll < 45) begin
                write_size($urandom_range(5, 4));
            end
            roll = $urandom_range(99);
            kind = (roll < 55) ? 0 : (roll < 70) ? 1 : (roll < 82) ? 2 : 3;
            send_matrix(kind);
        end

        drain();
        repeat (200) @(negedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
